// ===== sv/shk_pkg.sv =====
// ----------------------------------------------------------------------------
// shk_pkg: shared types and constants for the SVM histogram kernel engine.
// Holds kernel mode codes, register indexes, the sequencer state type and the
// queue entry type that travels from the accumulator to the finisher.
// ----------------------------------------------------------------------------
`default_nettype none
package shk_pkg;

  localparam int ELEMENT_WIDTH_DEF = 16;
  localparam int IN_W  = 16;
  localparam int SUM_W = 48;
  localparam int OUT_W = 32;

  // Pipelined square root: radicands below 2^50, first tested bit 2^48,
  // RT_STEPS iterations in each of RT_STAGES stages (25 in all).
  localparam int RT_W      = 52;
  localparam int RT_STAGES = 5;
  localparam int RT_STEPS  = 5;

  typedef enum logic [2:0] {
    MODE_HELL     = 3'd0,
    MODE_HELL_PRE = 3'd1,
    MODE_INTER    = 3'd2,
    MODE_LOWPASS  = 3'd3,
    MODE_LOG      = 3'd4,
    MODE_KMOD     = 3'd5,
    MODE_CAUCHY   = 3'd6,
    MODE_NONE     = 3'd7
  } kmode_t;

  localparam logic [1:0] REG_KERNEL_MODE = 2'd0;

  localparam logic [63:0] LN2_Q32     = 64'd2977044472;
  localparam logic [47:0] KMOD_S2_Q16 = 48'd983040;
  localparam logic [47:0] CAUCHY_S2   = 48'd589824;

  // Finished vector: final sum plus mode sampled at the last element.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    kmode_t           mode;
  } job_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_LOG,
    FS_DIV,
    FS_KMUL1,
    FS_KMUL2,
    FS_KMUL3,
    FS_DONE
  } fstate_t;

  // A slice of the bitwise square root: iterations step0 .. step0+RT_STEPS-1,
  // where iteration k tests bit 2^(48-2k). Returns {remainder, root}.
  function automatic logic [2*RT_W-1:0] root_steps(input logic [RT_W-1:0] x_in,
                                                   input logic [RT_W-1:0] r_in,
                                                   input int step0);
    logic [RT_W-1:0] x, r, b;
    x = x_in;
    r = r_in;
    for (int k = 0; k < RT_STEPS; k++) begin
      b = RT_W'(1) << (48 - 2 * (step0 + k));
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return {x, r};
  endfunction

endpackage
`default_nettype wire

// ===== sv/shk_if.sv =====
// ----------------------------------------------------------------------------
// shk_in_if / shk_out_if: valid/ready channels for elements and results.
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface shk_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_elem;
  logic [15:0] query_elem;
  logic        last;
  modport source (output valid, sample_elem, query_elem, last, input ready);
  modport sink   (input valid, sample_elem, query_elem, last, output ready);
endinterface

interface shk_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] kernel_value;
  logic               saturated;
  modport source (output valid, kernel_value, saturated, input ready);
  modport sink   (input valid, kernel_value, saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/shk_accum.sv =====
// ----------------------------------------------------------------------------
// shk_accum: front part. Takes one element pair per cycle unless held, forms the
// per-element term of the current mode and keeps the saturating running sum.
// ----------------------------------------------------------------------------
`default_nettype none
module shk_accum
  import shk_pkg::*;
#(
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [IN_W-1:0] in_s,
  input  wire logic [IN_W-1:0] in_q,
  input  wire logic            in_last,
  input  wire kmode_t          mode,
  output logic                 job_valid,
  input  wire logic            job_ready,
  output job_t                 job
);
  localparam int EW = (ELEMENT_WIDTH > IN_W) ? IN_W : ELEMENT_WIDTH;
  localparam logic [IN_W-1:0] EMASK = IN_W'((64'd1 << EW) - 64'd1);

  // Stage 1 registers: masked elements and mode.
  logic            v1_r;
  logic [IN_W-1:0] s1_r, q1_r, ps1_r, pq1_r;
  logic            last1_r, first1_r;
  kmode_t          mode1_r;
  // Square-root stages: stage 0 loads the radicands, the others iterate.
  logic            pv_r     [RT_STAGES+1];
  logic            plast_r  [RT_STAGES+1];
  logic            pfirst_r [RT_STAGES+1];
  kmode_t          pmode_r  [RT_STAGES+1];
  logic [47:0]     pterm_r  [RT_STAGES+1];
  logic [RT_W-1:0] ax_r     [RT_STAGES+1];
  logic [RT_W-1:0] ar_r     [RT_STAGES+1];
  logic [RT_W-1:0] bx_r     [RT_STAGES+1];
  logic [RT_W-1:0] br_r     [RT_STAGES+1];
  // Stage 2: term.
  logic            v2_r, last2_r, first2_r;
  logic [47:0]     term2_r;
  kmode_t          mode2_r;

  logic [SUM_W-1:0] sum_r;
  logic             first_r;
  logic [IN_W-1:0]  prev_s_r, prev_q_r;
  logic             jv_r;
  job_t             job_r;

  logic [IN_W-1:0] sm, qm;
  logic            adv;
  logic [47:0]     term1, term_fin;
  logic [RT_W-1:0] rad_a, rad_b, ra, rb;
  logic [15:0]     dd;
  logic [16:0]     as, aq;
  logic [33:0]     pp;
  logic [11:0]     rd;

  assign sm = in_s & EMASK;
  assign qm = in_q & EMASK;
  // The whole pipeline holds while a finished vector waits in the queue.
  assign adv = !(jv_r && !job_ready);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; first_r <= 1'b1;
      prev_s_r <= '0; prev_q_r <= '0;
      for (int j = 0; j <= RT_STAGES; j++) pv_r[j] <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      if (in_valid) begin
        s1_r <= sm; q1_r <= qm; ps1_r <= prev_s_r; pq1_r <= prev_q_r;
        last1_r <= in_last; first1_r <= first_r; mode1_r <= mode;
        prev_s_r <= sm; prev_q_r <= qm;
        first_r <= in_last;
      end
      pv_r[0] <= v1_r; plast_r[0] <= last1_r; pfirst_r[0] <= first1_r;
      pmode_r[0] <= mode1_r; pterm_r[0] <= term1;
      ax_r[0] <= rad_a; ar_r[0] <= '0; bx_r[0] <= rad_b; br_r[0] <= '0;
      for (int j = 1; j <= RT_STAGES; j++) begin
        pv_r[j] <= pv_r[j-1]; plast_r[j] <= plast_r[j-1];
        pfirst_r[j] <= pfirst_r[j-1]; pmode_r[j] <= pmode_r[j-1];
        pterm_r[j] <= pterm_r[j-1];
        {ax_r[j], ar_r[j]} <= root_steps(ax_r[j-1], ar_r[j-1], (j - 1) * RT_STEPS);
        {bx_r[j], br_r[j]} <= root_steps(bx_r[j-1], br_r[j-1], (j - 1) * RT_STEPS);
      end
      v2_r <= pv_r[RT_STAGES];
      last2_r <= plast_r[RT_STAGES]; first2_r <= pfirst_r[RT_STAGES];
      mode2_r <= pmode_r[RT_STAGES];
      term2_r <= term_fin;
    end
  end

  // Direct terms, and the radicands of the modes that need a square root.
  always_comb begin
    term1 = '0;
    rad_a = '0;
    rad_b = '0;
    dd = (s1_r > q1_r) ? s1_r - q1_r : q1_r - s1_r;
    as = 17'(s1_r) + 17'(ps1_r);
    aq = 17'(q1_r) + 17'(pq1_r);
    pp = 34'(as) * 34'(aq);
    case (mode1_r)
      MODE_HELL: begin
        rad_a = RT_W'(s1_r) << 8;
        rad_b = RT_W'(q1_r) << 8;
      end
      MODE_HELL_PRE, MODE_LOG, MODE_KMOD, MODE_CAUCHY: begin
        term1 = 48'(32'(dd) * 32'(dd));
      end
      MODE_INTER: term1 = 48'((s1_r < q1_r) ? s1_r : q1_r) << 8;
      MODE_LOWPASS: begin
        if (!first1_r)
          rad_a = RT_W'(pp) << 16;
      end
      default: term1 = '0;
    endcase
  end

  // Roots are done: finish the Hellinger and low-pass terms.
  assign ra = ar_r[RT_STAGES];
  assign rb = br_r[RT_STAGES];
  always_comb begin
    rd = '0;
    term_fin = pterm_r[RT_STAGES];
    case (pmode_r[RT_STAGES])
      MODE_HELL: begin
        rd = (ra > rb) ? 12'(ra - rb) : 12'(rb - ra);
        term_fin = 48'(24'(rd) * 24'(rd));
      end
      MODE_LOWPASS: term_fin = 48'(ra);
      default: term_fin = pterm_r[RT_STAGES];
    endcase
  end

  logic [SUM_W:0] acc;
  logic [SUM_W-1:0] nsum;
  assign acc  = (first2_r ? '0 : {1'b0, sum_r}) + {1'b0, term2_r};
  assign nsum = acc[SUM_W] ? '1 : acc[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jv_r <= 1'b0; sum_r <= '0;
    end else begin
      if (adv && v2_r) begin
        sum_r <= nsum;
        if (last2_r) begin
          job_r.sum <= nsum;
          job_r.mode <= mode2_r;
        end
      end
      if (adv && v2_r && last2_r) jv_r <= 1'b1;
      else if (jv_r && job_ready) jv_r <= 1'b0;
    end
  end
  assign job_valid = jv_r;
  assign job = job_r;
endmodule
`default_nettype wire

// ===== sv/shk_finish.sv =====
// ----------------------------------------------------------------------------
// shk_finish: back part. Turns a finished sum into the kernel value with a
// multi-cycle sequencer (log2 squaring, restoring divider, series multiply),
// saturates to Q16.16 and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module shk_finish
  import shk_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire job_t          job,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic signed [31:0] out_value,
  output logic               out_sat
);
  fstate_t st_r, st_nxt;
  kmode_t  mode_r;
  logic [SUM_W-1:0] z_r;
  logic [63:0] y_r, rem_r, quo_r, den_r, t_r, t2_r, acc_r;
  logic [31:0] t3_r;
  logic [5:0]  p_r;
  logic [6:0]  cnt_r;
  logic [15:0] frac_r;
  logic        ov_r;
  logic signed [31:0] val_r;
  logic        sat_r;

  // Next state and step datapath.
  logic [63:0]  sq, prod, d6;
  logic [64:0]  rsh;
  logic [5:0]   pos;
  logic [48:0]  zx;
  logic signed [64:0] v;
  logic         start;
  assign start = (st_r == FS_IDLE) && job_valid && !ov_r;
  assign job_ready = start;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      FS_IDLE:  if (start) begin
        case (job.mode)
          MODE_LOG:    st_nxt = FS_LOG;
          MODE_KMOD, MODE_CAUCHY: st_nxt = FS_DIV;
          default:     st_nxt = FS_DONE;
        endcase
      end
      FS_LOG:   if (cnt_r == 7'd15) st_nxt = FS_DONE;
      FS_DIV:   if (cnt_r == 7'd63) st_nxt = (mode_r == MODE_KMOD) ? FS_KMUL1 : FS_DONE;
      FS_KMUL1: st_nxt = FS_KMUL2;
      FS_KMUL2: st_nxt = FS_KMUL3;
      FS_KMUL3: st_nxt = FS_DONE;
      FS_DONE:  st_nxt = FS_IDLE;
      default:  st_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    zx = {1'b0, job.sum} + 49'd65536;
    pos = '0;
    for (int i = 0; i < 49; i++) if (zx[i]) pos = 6'(i);
  end
  // y stays below 2^31 and t, t2, t3 below 2^32, so 32-bit operands suffice.
  assign sq = {32'd0, y_r[31:0]} * {32'd0, y_r[31:0]};
  assign rsh = {rem_r, quo_r[63]};
  assign prod = {32'd0, t_r[31:0]} * {32'd0, (st_r == FS_KMUL1) ? t_r[31:0] : t2_r[31:0]};
  // floor(t3 / 6) by reciprocal multiplication, exact for 32-bit t3.
  assign d6 = {32'd0, t3_r} * 64'h0000_0000_AAAA_AAAB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FS_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (st_r == FS_DONE) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      FS_IDLE: if (start) begin
        mode_r <= job.mode; z_r <= job.sum; cnt_r <= '0; frac_r <= '0;
        p_r <= pos;
        y_r <= (pos > 6'd30) ? 64'(zx >> (pos - 6'd30)) : 64'(zx) << (6'd30 - pos);
        // Division: dividend shifted in bit by bit from quo_r.
        rem_r <= '0;
        if (job.mode == MODE_KMOD) begin
          quo_r <= 64'd7 << 48;
          den_r <= 64'd10 * (64'(job.sum) + 64'(KMOD_S2_Q16));
        end else begin
          quo_r <= 64'd9 << 32;
          den_r <= 64'(job.sum) + 64'(CAUCHY_S2);
        end
      end
      FS_LOG: begin
        cnt_r <= cnt_r + 7'd1;
        if (sq[63:30] >= 34'h0_8000_0000) begin
          y_r <= 64'(sq[63:31]); frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          y_r <= 64'(sq[63:30]); frac_r <= {frac_r[14:0], 1'b0};
        end
      end
      FS_DIV: begin
        cnt_r <= cnt_r + 7'd1;
        if (rsh >= {1'b0, den_r}) begin
          rem_r <= 64'(rsh - {1'b0, den_r}); quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rsh[63:0]; quo_r <= {quo_r[62:0], 1'b0};
        end
        t_r <= {quo_r[62:0], (rsh >= {1'b0, den_r})};
      end
      FS_KMUL1: t2_r <= {32'd0, prod[63:32]};
      FS_KMUL2: t3_r <= prod[63:32];
      FS_KMUL3: acc_r <= t_r + (t2_r >> 1) + 64'(d6[63:34]);
      default: ;
    endcase
  end

  // Final value and saturation, registered in FS_DONE.
  logic [63:0] lg;
  logic [63:0] lnp;
  always_comb begin
    lg  = ({58'd0, p_r} - 64'd16) << 16 | 64'(frac_r);
    lnp = {32'd0, lg[31:0]} * {32'd0, LN2_Q32[31:0]};
    case (mode_r)
      MODE_HELL, MODE_HELL_PRE: v = -65'(z_r);
      MODE_INTER, MODE_LOWPASS: v = 65'(z_r);
      MODE_LOG:    v = -65'(lnp[63:32]);
      MODE_KMOD:   v = 65'(acc_r >> 16);
      MODE_CAUCHY: v = {1'b0, quo_r};
      default:     v = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == FS_DONE) begin
      if (v > 65'sd2147483647) begin
        val_r <= 32'sh7fffffff; sat_r <= 1'b1;
      end else if (v < -65'sd2147483648) begin
        val_r <= 32'sh80000000; sat_r <= 1'b1;
      end else begin
        val_r <= v[31:0]; sat_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_value = val_r;
  assign out_sat   = sat_r;
endmodule
`default_nettype wire

// ===== sv/svm_histogram_kernel_engine.sv =====
// ----------------------------------------------------------------------------
// svm_histogram_kernel_engine: SVM kernel between streamed histogram pairs.
// Top level: APB register, accumulator front, finisher back.
// ----------------------------------------------------------------------------
// Element pairs are accepted one transaction per cycle, while the front is
// not held, by a pipelined accumulator: one stage registers the masked
// elements and forms the direct terms, six stages run a bitwise square root
// (a loading stage and five stages of five iterations), one stage finishes
// the term and the last adds it into a saturating 48-bit sum. A last element
// thus puts its sum and mode into a one-entry queue. The finisher turns the
// queued sum into the Q16.16 result: directly for the sum-based modes, with
// 16 squaring steps for log, with a 64-step restoring divider for Cauchy and
// with the divider plus three multiply steps for KMOD. The finisher takes a
// new entry only when it is idle and its output register is empty. The front
// keeps streaming the next vector while the finisher works; whenever a
// finished vector waits in the queue the whole front pipeline holds and
// input is stalled until the entry is taken. kernel_mode lies at byte
// address 0; mode 7 yields a zero result.
`default_nettype none
module svm_histogram_kernel_engine
  import shk_pkg::*;
#(
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  shk_in_if.sink           in_ch,
  shk_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  kmode_t mode_r;
  logic   job_valid, job_ready;
  job_t   job;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_HELL;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_KERNEL_MODE)
      mode_r <= kmode_t'(cfg_pwdata[2:0]);
  end
  assign cfg_prdata = (cfg_paddr == REG_KERNEL_MODE) ? {29'd0, mode_r} : '0;

  shk_accum #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_acc (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_s(in_ch.sample_elem), .in_q(in_ch.query_elem), .in_last(in_ch.last),
    .mode(mode_r), .job_valid, .job_ready, .job
  );

  shk_finish u_fin (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_value(out_ch.kernel_value), .out_sat(out_ch.saturated)
  );
endmodule
`default_nettype wire
